// ===== design/rcbp_pkg.sv =====
// Shared constants for the reference-counted buffer pool: field widths and codes.
package rcbp_pkg;

  // Field widths of the request and response transactions
  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int REFCNT_W = 16;
  localparam int TOTAL_W  = 7;

  // Capacity register width and the largest capacity it can express
  localparam int CAP_W     = 7;
  localparam int CAP_LIMIT = 127;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request operations
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_REF = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOOP      = 2'd2;

endpackage

// ===== design/rcbp_req_if.sv =====
// Request channel of the buffer pool: valid/ready handshake with operation and slot.
interface rcbp_req_if import rcbp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] slot;
  logic              slot_valid;

  modport source (output valid, output func, output slot, output slot_valid, input ready);
  modport sink   (input valid, input func, input slot, input slot_valid, output ready);
endinterface

// ===== design/rcbp_rsp_if.sv =====
// Response channel of the buffer pool: valid/ready handshake with status and counts.
interface rcbp_rsp_if import rcbp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_slot;
  logic [REFCNT_W-1:0] ref_count;
  logic [TOTAL_W-1:0]  in_use_count;

  modport source (output valid, output status, output granted_slot, output ref_count,
                  output in_use_count, input ready);
  modport sink   (input valid, input status, input granted_slot, input ref_count,
                  input in_use_count, output ready);
endinterface

// ===== design/refcounted_buffer_pool_top.sv =====
// Reference-counted buffer pool: top level with busy marks, count RAM and result register.
//
// Usage
//   in_req  : request transactions (func, slot, slot_valid), valid/ready.
//   out_rsp : one response per request (status, granted_slot, ref_count,
//             in_use_count), valid/ready, held in an output register.
//   cfg_we / cfg_wdata : writes pool_capacity; a write also empties the pool.
//             Write only while no request is outstanding.
// Timing
//   A request is taken in the idle state and its count is read from the count
//   RAM into the registered read port. In the update state the updated count
//   is written back and the response loads into the output register; the
//   update state waits while a held response still fills that register. One
//   request is taken per read-then-update pass over the count RAM: no new
//   request is accepted until the update state for the last one is done.
//   Acquire uses a priority encoder over the busy marks below the capacity.
// Reset
//   Capacity returns to 64, every busy mark and the in-use total clear at once.
//   Counts of free slots are never read, so the RAM needs no clearing pass.
// Stall
//   With out_rsp.ready low the response holds; a request already taken waits
//   in the update state and no further request is accepted until it leaves.
module refcounted_buffer_pool_top import rcbp_pkg::*; #(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  rcbp_req_if.sink         in_req,
  rcbp_rsp_if.source       out_rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  // Only slots the capacity register can reach get storage
  localparam int USE_SLOTS = (SLOTS > CAP_LIMIT) ? CAP_LIMIT : SLOTS;
  localparam int ADDR_W    = $clog2(USE_SLOTS);
  localparam int TOT_W     = $clog2(USE_SLOTS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                  state_r, state_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [USE_SLOTS-1:0]  busy_r, busy_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;

  logic [FUNC_W-1:0]     func_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  slot_valid_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_W-1:0]     out_granted_r;
  logic [REFCNT_W-1:0]   out_count_r;
  logic [TOTAL_W-1:0]    out_total_r;

  logic                  accept;
  logic                  exec_fire;
  logic [CAP_W-1:0]      cap_eff;
  logic [USE_SLOTS-1:0]  free_vec;
  logic [ADDR_W-1:0]     acq_idx;
  logic                  acq_found;
  logic [ADDR_W-1:0]     slot_addr;
  logic                  slot_hit;

  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_res;
  logic [STATUS_W-1:0]   status_res;
  logic [ADDR_W-1:0]     granted_res;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  set_busy;
  logic                  clr_busy;
  logic [31:0]           cnt_wide;
  logic [31:0]           granted_wide;

  assign accept    = in_req.valid & in_req.ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);

  // Count RAM: read at acceptance, written back in the update cycle.
  // Write and the next read always fall in different cycles.
  rcbp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (USE_SLOTS)
  ) u_count_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (cnt_res),
    .re      (accept),
    .raddr   (ADDR_W'(in_req.slot)),
    .rdata_r (cnt_rd)
  );

  // Effective capacity, saturated at the slot storage
  assign cap_eff = (cap_r > CAP_W'(USE_SLOTS)) ? CAP_W'(USE_SLOTS) : cap_r;

  // Free slots below the capacity
  always_comb begin
    for (int i = 0; i < USE_SLOTS; i++) begin
      free_vec[i] = !busy_r[i] && (CAP_W'(i) < cap_eff);
    end
  end

  // Lowest free slot
  always_comb begin
    acq_idx   = '0;
    acq_found = 1'b0;
    for (int i = USE_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        acq_idx   = ADDR_W'(i);
        acq_found = 1'b1;
      end
    end
  end

  // Addressed slot must be valid, below capacity and in use
  assign slot_addr = ADDR_W'(slot_r);
  assign slot_hit  = slot_valid_r && (CAP_W'(slot_r) < cap_eff) && busy_r[slot_addr];

  // Operation: new count, status and write-back
  always_comb begin
    status_res  = STATUS_NOOP;
    granted_res = '0;
    cnt_res     = '0;
    ram_we      = 1'b0;
    ram_waddr   = slot_addr;
    set_busy    = 1'b0;
    clr_busy    = 1'b0;
    case (func_r)
      FUNC_ACQUIRE: begin
        if (acq_found) begin
          status_res  = STATUS_OK;
          granted_res = acq_idx;
          cnt_res     = COUNT_BITS'(1);
          ram_we      = exec_fire;
          ram_waddr   = acq_idx;
          set_busy    = 1'b1;
        end else begin
          status_res = STATUS_EXHAUSTED;
        end
      end
      FUNC_ADD_REF: begin
        if (slot_hit) begin
          status_res = STATUS_OK;
          cnt_res    = (cnt_rd == '1) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
          ram_we     = exec_fire;
        end
      end
      FUNC_RELEASE: begin
        if (slot_hit) begin
          status_res = STATUS_OK;
          cnt_res    = (cnt_rd != '0) ? cnt_rd - COUNT_BITS'(1) : cnt_rd;
          ram_we     = exec_fire;
          clr_busy   = (cnt_res == '0);
        end
      end
      FUNC_QUERY: begin
        if (slot_hit) begin
          status_res = STATUS_OK;
          cnt_res    = cnt_rd;
        end
      end
      default: begin
        status_res = STATUS_NOOP;
      end
    endcase
  end

  // Busy marks, in-use total and capacity; a capacity write empties the pool
  always_comb begin
    busy_nxt  = busy_r;
    total_nxt = total_r;
    cap_nxt   = cap_r;
    if (cfg_we) begin
      cap_nxt   = cfg_wdata;
      busy_nxt  = '0;
      total_nxt = '0;
    end else if (exec_fire) begin
      if (set_busy) begin
        busy_nxt[acq_idx] = 1'b1;
        total_nxt         = total_r + TOT_W'(1);
      end
      if (clr_busy) begin
        busy_nxt[slot_addr] = 1'b0;
        total_nxt           = total_r - TOT_W'(1);
      end
    end
  end

  // Sequencer: idle takes a request, update waits for a free output register
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      busy_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      busy_r      <= busy_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and response payload registers
  assign cnt_wide     = 32'(cnt_res);
  assign granted_wide = 32'(granted_res);

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_req.func;
      slot_r       <= in_req.slot;
      slot_valid_r <= in_req.slot_valid;
    end
    if (exec_fire) begin
      out_status_r  <= status_res;
      out_granted_r <= granted_wide[SLOT_W-1:0];
      out_count_r   <= cnt_wide[REFCNT_W-1:0];
      out_total_r   <= TOTAL_W'(total_nxt);
    end
  end

  // Channel outputs
  assign in_req.ready         = (state_r == S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.granted_slot = out_granted_r;
  assign out_rsp.ref_count    = out_count_r;
  assign out_rsp.in_use_count = out_total_r;

endmodule

// ===== design/rcbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
